FILE: rtl/wer_pkg.sv
// Package for the wind error ratio check pipeline.
// Holds field widths, status codes, register indexes and the stage tag struct.
// No dependencies; used by every module under rtl/.
`default_nettype none

package wer_pkg;

    // Field and datapath widths
    localparam int COMP_W   = 16;  // signed wind component
    localparam int MAG_W    = 17;  // magnitude of a component, holds 32768
    localparam int SQ_W     = 31;  // square of a magnitude
    localparam int REG_W    = 15;  // configuration register width
    localparam int FLSQ_W   = 30;  // square of the speed floor
    localparam int SUM_W    = 32;  // east^2 + north^2
    localparam int ERR_W    = 7;   // 100 - code
    localparam int ERRSQ_W  = 14;  // (100 - code)^2
    localparam int DEN_W    = 38;  // 100 * (east^2 + north^2)
    localparam int QUO_W    = 32;  // quotient handed to the square root
    localparam int HEAD_W   = 12;  // upper bits of the dividend, initial remainder
    localparam int ROOT_W   = 16;  // square root and ratio width
    localparam int SREM_W   = 18;  // square root remainder
    localparam int DIV_BITS = 32;  // one quotient bit per divider stage
    localparam int SQRT_STEPS = 16; // one root bit per square root stage

    // Error code range
    localparam logic [7:0] CODE_MAX = 8'd100;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISSING  = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // Configuration register indexes
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_MIN_COMPONENT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_FLOOR   = 2'd1;

    // Side information that travels with each item through the pipeline
    typedef struct packed {
        logic [1:0] status;  // final status code
        logic       zero;    // force the ratio to zero
        logic       ovf;     // quotient does not fit, saturate the ratio
    } wer_tag_t;

endpackage

`default_nettype wire

FILE: rtl/wind_error_ratio_check.sv
// Wind error ratio check: for each wind observation, the expected error over the
// wind speed in 1/32768 units, with a status code.
//
// Input channel: in_valid / in_stall carry wind_east, wind_north, east_valid,
// north_valid and error_code; a transaction completes when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall carry error_ratio and
// status, one result transaction per input transaction, in order.
// Configuration: wr_en, wr_index, wr_data write min_component (index 0) and
// speed_floor (index 1); other indexes are ignored. Write only while idle.
//
// Throughput: one item per cycle while in_stall is low. The path holds 53
// register stages: four setup stages, a 32-stage restoring divider and a 16-stage
// square root, then an output register backed by a skid register. When out_stall
// holds the output, the pipeline keeps running until the skid register fills;
// only then does in_stall rise, and no transaction is lost. Reset clears all
// valid bits, empties the output and sets min_component to 1 and speed_floor to 13.
// Depends on wer_pkg, wer_prep, wer_div and wer_sqrt.
`default_nettype none

module wind_error_ratio_check (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [wer_pkg::COMP_W-1:0] wind_east,
    input  wire logic signed [wer_pkg::COMP_W-1:0] wind_north,
    input  wire logic                              east_valid,
    input  wire logic                              north_valid,
    input  wire logic [7:0]                        error_code,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [wer_pkg::ROOT_W-1:0]             error_ratio,
    output logic [1:0]                             status,
    input  wire logic                              wr_en,
    input  wire logic [wer_pkg::IDX_W-1:0]         wr_index,
    input  wire logic [wer_pkg::REG_W-1:0]         wr_data
);

    logic [wer_pkg::REG_W-1:0]   min_component_reg;
    logic [wer_pkg::REG_W-1:0]   speed_floor_reg;

    logic                        advance;
    logic                        in_take;

    logic                        prep_valid;
    logic [wer_pkg::DEN_W-1:0]   prep_den;
    logic [wer_pkg::HEAD_W-1:0]  prep_head;
    logic [1:0]                  prep_low2;
    wer_pkg::wer_tag_t           prep_tag;

    logic                        div_valid;
    logic [wer_pkg::QUO_W-1:0]   div_quo;
    wer_pkg::wer_tag_t           div_tag;

    logic                        sq_valid;
    logic [wer_pkg::ROOT_W-1:0]  sq_root;
    wer_pkg::wer_tag_t           sq_tag;

    logic [wer_pkg::ROOT_W-1:0]  res_ratio;
    logic                        emit;
    logic                        out_take;

    logic                        out_valid_reg;
    logic [wer_pkg::ROOT_W-1:0]  out_ratio_reg;
    logic [1:0]                  out_status_reg;
    logic                        skid_valid_reg;
    logic [wer_pkg::ROOT_W-1:0]  skid_ratio_reg;
    logic [1:0]                  skid_status_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_component_reg <= wer_pkg::REG_W'(1);
            speed_floor_reg   <= wer_pkg::REG_W'(13);
        end
        else if (wr_en)
        begin
            case (wr_index)
                wer_pkg::REG_MIN_COMPONENT: min_component_reg <= wr_data;
                wer_pkg::REG_SPEED_FLOOR:   speed_floor_reg   <= wr_data;
                default:                    ;
            endcase
        end
    end

    // Freeze the pipeline only while the skid register is full
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && advance;

    wer_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_take       (in_take),
        .wind_east     (wind_east),
        .wind_north    (wind_north),
        .east_valid    (east_valid),
        .north_valid   (north_valid),
        .error_code    (error_code),
        .min_component (min_component_reg),
        .speed_floor   (speed_floor_reg),
        .valid         (prep_valid),
        .den           (prep_den),
        .head          (prep_head),
        .low2          (prep_low2),
        .tag           (prep_tag)
    );

    wer_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (prep_valid),
        .den       (prep_den),
        .head      (prep_head),
        .low2      (prep_low2),
        .in_tag    (prep_tag),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_tag   (div_tag)
    );

    wer_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (div_valid),
        .operand   (div_quo),
        .in_tag    (div_tag),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // Pick the final ratio: zero, saturated or the root
    always_comb
    begin
        if (sq_tag.zero)
        begin
            res_ratio = '0;
        end
        else if (sq_tag.ovf)
        begin
            res_ratio = '1;
        end
        else
        begin
            res_ratio = sq_root;
        end
    end

    assign emit     = advance && sq_valid;
    assign out_take = out_valid_reg && !out_stall;

    // Output register and skid register: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg  <= skid_valid_reg || emit;
            skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid register: payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_ratio_reg  <= skid_ratio_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_ratio_reg  <= res_ratio;
                out_status_reg <= sq_tag.status;
            end
        end
        else if (emit)
        begin
            skid_ratio_reg  <= res_ratio;
            skid_status_reg <= sq_tag.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign error_ratio = out_ratio_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/wer_prep.sv
// Front stages of the wind error ratio check: magnitudes, squares, case sorting
// and the scaled divisor. Four register stages.
// Depends on wer_pkg.
`default_nettype none

module wer_prep (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic                            in_take,
    input  wire logic signed [wer_pkg::COMP_W-1:0] wind_east,
    input  wire logic signed [wer_pkg::COMP_W-1:0] wind_north,
    input  wire logic                            east_valid,
    input  wire logic                            north_valid,
    input  wire logic [7:0]                      error_code,
    input  wire logic [wer_pkg::REG_W-1:0]       min_component,
    input  wire logic [wer_pkg::REG_W-1:0]       speed_floor,
    output logic                                 valid,
    output logic [wer_pkg::DEN_W-1:0]            den,
    output logic [wer_pkg::HEAD_W-1:0]           head,
    output logic [1:0]                           low2,
    output wer_pkg::wer_tag_t                    tag
);

    // Stage 1: magnitudes and flags
    logic                         s1_valid_reg;
    logic [wer_pkg::MAG_W-1:0]    s1_ae_reg, s1_an_reg;
    logic [wer_pkg::MAG_W-1:0]    s1_ae_next, s1_an_next;
    logic                         s1_miss_reg, s1_calm_reg, s1_bad_reg;
    logic                         s1_miss_next, s1_calm_next, s1_bad_next;
    logic [wer_pkg::ERR_W-1:0]    s1_err_reg, s1_err_next;
    logic [wer_pkg::REG_W-1:0]    thr;

    // Stage 2: squares
    logic                         s2_valid_reg;
    logic [wer_pkg::SQ_W-1:0]     s2_sqe_reg, s2_sqn_reg, s2_sqe_next, s2_sqn_next;
    logic [wer_pkg::FLSQ_W-1:0]   s2_flsq_reg, s2_flsq_next;
    logic [wer_pkg::ERRSQ_W-1:0]  s2_errsq_reg, s2_errsq_next;
    logic                         s2_miss_reg, s2_calm_reg, s2_bad_reg;

    // Stage 3: sum of squares and case sorting
    logic                         s3_valid_reg;
    logic [wer_pkg::SUM_W-1:0]    s3_sum_reg, s3_sum_next;
    logic [wer_pkg::ERRSQ_W-1:0]  s3_errsq_reg;
    wer_pkg::wer_tag_t            s3_tag_reg, s3_tag_next;

    // Stage 4: divisor 100 * sum
    logic                         s4_valid_reg;
    logic [wer_pkg::DEN_W-1:0]    s4_den_reg, s4_den_next;
    logic [wer_pkg::ERRSQ_W-1:0]  s4_errsq_reg;
    wer_pkg::wer_tag_t            s4_tag_reg;

    // Magnitudes of the components, the calm test and the missing and code checks
    always_comb
    begin
        thr = (min_component == '0) ? wer_pkg::REG_W'(1) : min_component;
        s1_ae_next = wind_east[wer_pkg::COMP_W-1]
                   ? wer_pkg::MAG_W'(0) - {1'b1, wind_east}
                   : {1'b0, wind_east};
        s1_an_next = wind_north[wer_pkg::COMP_W-1]
                   ? wer_pkg::MAG_W'(0) - {1'b1, wind_north}
                   : {1'b0, wind_north};
        s1_miss_next = !east_valid || !north_valid;
        s1_calm_next = (s1_ae_next < {2'b00, thr}) && (s1_an_next < {2'b00, thr});
        s1_bad_next  = error_code > wer_pkg::CODE_MAX;
        s1_err_next  = wer_pkg::ERR_W'(wer_pkg::CODE_MAX - error_code);
    end

    // Squares of the magnitudes, the floor and the expected error
    always_comb
    begin
        s2_sqe_next   = wer_pkg::SQ_W'(s1_ae_reg * s1_ae_reg);
        s2_sqn_next   = wer_pkg::SQ_W'(s1_an_reg * s1_an_reg);
        s2_flsq_next  = wer_pkg::FLSQ_W'(speed_floor * speed_floor);
        s2_errsq_next = wer_pkg::ERRSQ_W'(s1_err_reg * s1_err_reg);
    end

    // Sort the item into its case
    always_comb
    begin
        s3_sum_next = {1'b0, s2_sqe_reg} + {1'b0, s2_sqn_reg};
        s3_tag_next.ovf = 1'b0;
        if (s2_miss_reg)
        begin
            s3_tag_next.status = wer_pkg::STATUS_MISSING;
            s3_tag_next.zero   = 1'b1;
        end
        else if (s2_calm_reg)
        begin
            s3_tag_next.status = wer_pkg::STATUS_OK;
            s3_tag_next.zero   = 1'b1;
        end
        else if (s3_sum_next <= {2'b00, s2_flsq_reg} || s2_bad_reg)
        begin
            s3_tag_next.status = wer_pkg::STATUS_REJECTED;
            s3_tag_next.zero   = 1'b1;
        end
        else
        begin
            s3_tag_next.status = wer_pkg::STATUS_OK;
            s3_tag_next.zero   = 1'b0;
        end
    end

    // Scale the sum by 100 with shifts and adds
    always_comb
    begin
        s4_den_next = ({6'd0, s3_sum_reg} << 6) + ({6'd0, s3_sum_reg} << 5)
                    + ({6'd0, s3_sum_reg} << 2);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ae_reg    <= s1_ae_next;
            s1_an_reg    <= s1_an_next;
            s1_miss_reg  <= s1_miss_next;
            s1_calm_reg  <= s1_calm_next;
            s1_bad_reg   <= s1_bad_next;
            s1_err_reg   <= s1_err_next;
            s2_sqe_reg   <= s2_sqe_next;
            s2_sqn_reg   <= s2_sqn_next;
            s2_flsq_reg  <= s2_flsq_next;
            s2_errsq_reg <= s2_errsq_next;
            s2_miss_reg  <= s1_miss_reg;
            s2_calm_reg  <= s1_calm_reg;
            s2_bad_reg   <= s1_bad_reg;
            s3_sum_reg   <= s3_sum_next;
            s3_errsq_reg <= s2_errsq_reg;
            s3_tag_reg   <= s3_tag_next;
            s4_den_reg   <= s4_den_next;
            s4_errsq_reg <= s3_errsq_reg;
            s4_tag_reg   <= s3_tag_reg;
        end
    end

    // Dividend is errsq * 2^30; its top bits seed the remainder
    assign valid = s4_valid_reg;
    assign den   = s4_den_reg;
    assign head  = s4_errsq_reg[wer_pkg::ERRSQ_W-1:2];
    assign low2  = s4_errsq_reg[1:0];
    assign tag   = s4_tag_reg;

endmodule

`default_nettype wire

FILE: rtl/wer_div.sv
// Restoring divider of the wind error ratio check, one quotient bit per stage.
// Gives floor(errsq * 2^30 / den) as 32 bits plus an overflow flag.
// Depends on wer_pkg.
`default_nettype none

module wer_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         in_valid,
    input  wire logic [wer_pkg::DEN_W-1:0]    den,
    input  wire logic [wer_pkg::HEAD_W-1:0]   head,
    input  wire logic [1:0]                   low2,
    input  wire wer_pkg::wer_tag_t            in_tag,
    output logic                              out_valid,
    output logic [wer_pkg::QUO_W-1:0]         quo,
    output wer_pkg::wer_tag_t                 out_tag
);

    localparam int N = wer_pkg::DIV_BITS;
    localparam int W = wer_pkg::DEN_W;

    // Stage inputs
    logic                       v_in   [N];
    logic [W-1:0]               r_in   [N];
    logic [wer_pkg::QUO_W-1:0]  q_in   [N];
    logic [W-1:0]               d_in   [N];
    logic [wer_pkg::QUO_W-1:0]  lo_in  [N];
    wer_pkg::wer_tag_t          t_in   [N];

    // Stage registers
    logic                       v_reg  [N];
    logic [W-1:0]               r_reg  [N];
    logic [W-1:0]               r_next [N];
    logic [wer_pkg::QUO_W-1:0]  q_reg  [N];
    logic [wer_pkg::QUO_W-1:0]  q_next [N];
    logic [W-1:0]               d_reg  [N];
    logic [wer_pkg::QUO_W-1:0]  lo_reg [N];
    wer_pkg::wer_tag_t          t_reg  [N];

    wer_pkg::wer_tag_t          first_tag;

    // Overflow when the quotient needs more than 32 bits
    always_comb
    begin
        first_tag     = in_tag;
        first_tag.ovf = {{(W-wer_pkg::HEAD_W){1'b0}}, head} >= den;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [W:0] shifted;
        logic       fits;

        // Feed the stage from the ports or from the stage before
        if (k == 0)
        begin : g_first
            assign v_in[k]  = in_valid;
            assign r_in[k]  = {{(W-wer_pkg::HEAD_W){1'b0}}, head};
            assign q_in[k]  = '0;
            assign d_in[k]  = den;
            assign lo_in[k] = {low2, {(wer_pkg::QUO_W-2){1'b0}}};
            assign t_in[k]  = first_tag;
        end
        else
        begin : g_next
            assign v_in[k]  = v_reg[k-1];
            assign r_in[k]  = r_reg[k-1];
            assign q_in[k]  = q_reg[k-1];
            assign d_in[k]  = d_reg[k-1];
            assign lo_in[k] = lo_reg[k-1];
            assign t_in[k]  = t_reg[k-1];
        end

        // Shift in one dividend bit, subtract if the divisor fits
        always_comb
        begin
            shifted   = {r_in[k], lo_in[k][wer_pkg::QUO_W-1]};
            fits      = shifted >= {1'b0, d_in[k]};
            r_next[k] = fits ? W'(shifted - {1'b0, d_in[k]}) : shifted[W-1:0];
            q_next[k] = {q_in[k][wer_pkg::QUO_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                r_reg[k]  <= r_next[k];
                q_reg[k]  <= q_next[k];
                d_reg[k]  <= d_in[k];
                lo_reg[k] <= lo_in[k] << 1;
                t_reg[k]  <= t_in[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quo       = q_reg[N-1];
    assign out_tag   = t_reg[N-1];

endmodule

`default_nettype wire

FILE: rtl/wer_sqrt.sv
// Restoring integer square root of the wind error ratio check, one root bit
// per stage over a 32-bit operand. Depends on wer_pkg.
`default_nettype none

module wer_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         in_valid,
    input  wire logic [wer_pkg::QUO_W-1:0]    operand,
    input  wire wer_pkg::wer_tag_t            in_tag,
    output logic                              out_valid,
    output logic [wer_pkg::ROOT_W-1:0]        root,
    output wer_pkg::wer_tag_t                 out_tag
);

    localparam int N  = wer_pkg::SQRT_STEPS;
    localparam int RW = wer_pkg::SREM_W;
    localparam int QW = wer_pkg::ROOT_W;
    localparam int UW = wer_pkg::QUO_W;

    logic               v_in   [N];
    logic [UW-1:0]      u_in   [N];
    logic [RW-1:0]      r_in   [N];
    logic [QW-1:0]      q_in   [N];
    wer_pkg::wer_tag_t  t_in   [N];

    logic               v_reg  [N];
    logic [UW-1:0]      u_reg  [N];
    logic [RW-1:0]      r_reg  [N];
    logic [RW-1:0]      r_next [N];
    logic [QW-1:0]      q_reg  [N];
    logic [QW-1:0]      q_next [N];
    wer_pkg::wer_tag_t  t_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [RW+1:0] shifted;
        logic [RW+1:0] trial;
        logic          fits;

        // Feed the stage from the ports or from the stage before
        if (k == 0)
        begin : g_first
            assign v_in[k] = in_valid;
            assign u_in[k] = operand;
            assign r_in[k] = '0;
            assign q_in[k] = '0;
            assign t_in[k] = in_tag;
        end
        else
        begin : g_next
            assign v_in[k] = v_reg[k-1];
            assign u_in[k] = u_reg[k-1];
            assign r_in[k] = r_reg[k-1];
            assign q_in[k] = q_reg[k-1];
            assign t_in[k] = t_reg[k-1];
        end

        // Bring down two operand bits and try root*4 + 1
        always_comb
        begin
            shifted   = {r_in[k], u_in[k][UW-1:UW-2]};
            trial     = {{(RW-QW){1'b0}}, q_in[k], 2'b01};
            fits      = shifted >= trial;
            r_next[k] = fits ? RW'(shifted - trial) : shifted[RW-1:0];
            q_next[k] = {q_in[k][QW-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                u_reg[k] <= u_in[k] << 2;
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
                t_reg[k] <= t_in[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = q_reg[N-1];
    assign out_tag   = t_reg[N-1];

endmodule

`default_nettype wire
